// ----- rtl/csvfs_pkg.sv -----
// ----------------------------------------------------------------------------
// csvfs_pkg: shared types and constants of the csv field splitter
// item payloads, parse modes and the action entry between front and back
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

   localparam logic [7:0] QUOTE_BYTE    = 8'h22;
   localparam logic [7:0] CR_BYTE       = 8'h0D;
   localparam logic [7:0] LF_BYTE       = 8'h0A;
   localparam logic [7:0] NUL_BYTE      = 8'h00;
   localparam logic [7:0] SEP_RESET     = 8'd44;

   localparam logic       KIND_CONTENT  = 1'b0;
   localparam logic       KIND_FIELDEND = 1'b1;

   typedef enum logic [2:0] {
      MODE_LINE_START  = 3'd0,
      MODE_FIELD_START = 3'd1,
      MODE_UNQUOTED    = 3'd2,
      MODE_QUOTED      = 3'd3,
      MODE_AFTER_QUOTE = 3'd4
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] content_byte;
      logic       record_end;
   } rsp_type;

   // one queued action: a single result, or (two set) a record-ending
   // field end followed by the content byte held in res
   typedef struct packed {
      logic    two;
      rsp_type res;
   } entry_type;

   // queue status seen by the two sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ----- rtl/csvfs_front.sv -----
// ----------------------------------------------------------------------------
// csvfs_front: byte classifier
// holds the separator and the parse mode, turns each byte into at most one queue action
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  csvfs_pkg::req_type   req_payload,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [7:0]            csr_data,
   input  csvfs_pkg::qstat_type qstat,
   output logic                 push,
   output csvfs_pkg::entry_type push_entry
);

   csvfs_pkg::mode_type mode_ff, mode_in;
   logic [7:0]          sep_ff;
   logic                accept;
   logic                eot;
   logic                is_eol;
   logic [7:0]          b;
   logic                emit;

   assign req_stall = qstat.full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !qstat.full;
   assign b         = req_payload.text_byte;
   assign eot       = req_payload.end_of_text || (b == csvfs_pkg::NUL_BYTE);
   assign is_eol    = (b == csvfs_pkg::CR_BYTE) || (b == csvfs_pkg::LF_BYTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff  <= csvfs_pkg::SEP_RESET;
         mode_ff <= csvfs_pkg::MODE_LINE_START;
      end else begin
         if (csr_valid) begin
            sep_ff <= csr_data;
         end
         if (accept) begin
            mode_ff <= mode_in;
         end
      end
   end

   always_comb begin
      mode_in               = mode_ff;
      emit                  = 1'b0;
      push_entry.two        = 1'b0;
      push_entry.res.kind   = csvfs_pkg::KIND_FIELDEND;
      push_entry.res.content_byte = csvfs_pkg::NUL_BYTE;
      push_entry.res.record_end   = 1'b0;
      if (eot) begin
         emit                      = (mode_ff != csvfs_pkg::MODE_LINE_START);
         push_entry.res.record_end = 1'b1;
         mode_in                   = csvfs_pkg::MODE_LINE_START;
      end else begin
         unique case (mode_ff)
            csvfs_pkg::MODE_UNQUOTED: begin
               priority if (b == sep_ff) begin
                  emit    = 1'b1;
                  mode_in = csvfs_pkg::MODE_FIELD_START;
               end else if (is_eol) begin
                  emit                      = 1'b1;
                  push_entry.res.record_end = 1'b1;
                  mode_in                   = csvfs_pkg::MODE_LINE_START;
               end else begin
                  emit                        = 1'b1;
                  push_entry.res.kind         = csvfs_pkg::KIND_CONTENT;
                  push_entry.res.content_byte = b;
               end
            end
            csvfs_pkg::MODE_QUOTED: begin
               if (b == csvfs_pkg::QUOTE_BYTE) begin
                  mode_in = csvfs_pkg::MODE_AFTER_QUOTE;
               end else begin
                  emit                        = 1'b1;
                  push_entry.res.kind         = csvfs_pkg::KIND_CONTENT;
                  push_entry.res.content_byte = b;
               end
            end
            csvfs_pkg::MODE_AFTER_QUOTE: begin
               priority if (b == csvfs_pkg::QUOTE_BYTE) begin
                  emit                        = 1'b1;
                  push_entry.res.kind         = csvfs_pkg::KIND_CONTENT;
                  push_entry.res.content_byte = csvfs_pkg::QUOTE_BYTE;
                  mode_in                     = csvfs_pkg::MODE_QUOTED;
               end else if (b == sep_ff) begin
                  emit    = 1'b1;
                  mode_in = csvfs_pkg::MODE_FIELD_START;
               end else if (is_eol) begin
                  emit                      = 1'b1;
                  push_entry.res.record_end = 1'b1;
                  mode_in                   = csvfs_pkg::MODE_LINE_START;
               end else begin
                  // stray byte: record end, then b opens a new record
                  emit                        = 1'b1;
                  push_entry.two              = 1'b1;
                  push_entry.res.kind         = csvfs_pkg::KIND_CONTENT;
                  push_entry.res.content_byte = b;
                  mode_in                     = csvfs_pkg::MODE_UNQUOTED;
               end
            end
            default: begin
               // line start, field start and unused codes
               priority if ((mode_ff != csvfs_pkg::MODE_FIELD_START) && is_eol) begin
                  mode_in = csvfs_pkg::MODE_LINE_START;
               end else if (b == csvfs_pkg::QUOTE_BYTE) begin
                  mode_in = csvfs_pkg::MODE_QUOTED;
               end else if (b == sep_ff) begin
                  emit    = 1'b1;
                  mode_in = csvfs_pkg::MODE_FIELD_START;
               end else if (is_eol) begin
                  emit                      = 1'b1;
                  push_entry.res.record_end = 1'b1;
                  mode_in                   = csvfs_pkg::MODE_LINE_START;
               end else begin
                  emit                        = 1'b1;
                  push_entry.res.kind         = csvfs_pkg::KIND_CONTENT;
                  push_entry.res.content_byte = b;
                  mode_in                     = csvfs_pkg::MODE_UNQUOTED;
               end
            end
         endcase
      end
      push = accept && emit;
   end

   a_eot_line_start: assert property (@(posedge clock) disable iff (reset)
      accept && eot |=> mode_ff == csvfs_pkg::MODE_LINE_START)
      else $error("mode not back at line start after end of text");

endmodule

`default_nettype wire

// ----- rtl/csvfs_queue.sv -----
// ----------------------------------------------------------------------------
// csvfs_queue: action queue
// small register fifo that decouples the classifier from the result stage
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_queue #(
   parameter int DEPTH = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  csvfs_pkg::entry_type push_entry,
   input  wire                  pop,
   output csvfs_pkg::entry_type head,
   output csvfs_pkg::qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   csvfs_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/csvfs_back.sv -----
// ----------------------------------------------------------------------------
// csvfs_back: result stage
// expands queued actions into result items in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_back (
   input  wire                  clock,
   input  wire                  reset,
   input  csvfs_pkg::entry_type head,
   input  csvfs_pkg::qstat_type qstat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output csvfs_pkg::rsp_type   rsp_payload
);

   logic               rsp_valid_ff, rsp_valid_in;
   csvfs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               phase_ff, phase_in;
   logic               load;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign load        = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = !qstat.empty;
         if (!qstat.empty) begin
            if (head.two && !phase_ff) begin
               // record end ahead of the stray byte
               rsp_data_in.kind         = csvfs_pkg::KIND_FIELDEND;
               rsp_data_in.content_byte = csvfs_pkg::NUL_BYTE;
               rsp_data_in.record_end   = 1'b1;
               phase_in                 = 1'b1;
            end else begin
               rsp_data_in = head.res;
               phase_in    = 1'b0;
               pop         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_phase_has_item: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> rsp_valid_ff && rsp_data_ff.record_end)
      else $error("second half pending without record end shown");

   a_phase_done: assert property (@(posedge clock) disable iff (reset)
      phase_ff && !rsp_stall |=> !phase_ff && rsp_valid_ff)
      else $error("second result of a stray byte not delivered");

endmodule

`default_nettype wire

// ----- rtl/csv_field_splitter.sv -----
// ----------------------------------------------------------------------------
// csv_field_splitter: streaming csv field splitter
// splits csv text bytes into field content bytes and field/record end marks
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake              payload
//  req_*        in   req_valid / req_stall  req_type: text_byte, end_of_text
//  rsp_*        out  rsp_valid / rsp_stall  rsp_type: kind, content_byte,
//                                           record_end
//  csr_*        in   csr_valid / csr_ready  csr_data: separator byte
//
//  one item accepted per cycle while req_stall is low; its results pass the action
//    queue and the output register; a stray byte after a closing quote yields two
//    items and holds the result stage for the second; the queue absorbs the hold
//  req_stall rises only when the QUEUE_DEPTH-entry action queue is full
//  reset: separator 44, parse mode line start, queue and output empty
//  csr_ready is always high; write the separator only while idle
//
`default_nettype none

module csv_field_splitter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                clock,
   input  wire                reset,
   // text bytes in
   input  wire                req_valid,
   output logic               req_stall,
   input  csvfs_pkg::req_type req_payload,
   // field items out
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output csvfs_pkg::rsp_type rsp_payload,
   // separator register
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [7:0]          csr_data
);

   csvfs_pkg::qstat_type qstat;
   csvfs_pkg::entry_type push_entry;
   csvfs_pkg::entry_type head;
   logic                 push;
   logic                 pop;

   // front: classify each byte against the parse mode
   csvfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .qstat       (qstat),
      .push        (push),
      .push_entry  (push_entry)
   );

   // queue of pending actions, bytes that yield no item never enter it
   csvfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   // back: one result item per cycle into the output register while rsp_stall is low
   csvfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- sim/tb_csv_field_splitter.sv -----
// ----------------------------------------------------------------------------
// tb_csv_field_splitter: self-checking bench of the csv field splitter
// feeds csv text bytes under random idling and back-pressure, predicts the
// field items of every accepted byte and checks them in order at the output
// ----------------------------------------------------------------------------
`default_nettype none

module tb_csv_field_splitter;

   localparam int SETTLE         = 8;     // cycles for in-flight bytes with no item
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
   localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
   localparam int PHASE_ITEMS    = 150;   // random text bytes per separator setting
   localparam int PHASES         = 9;
   localparam int REPORT_LIMIT   = 10;

   // separators of the random phases, the last one is drawn at run time
   localparam logic [7:0] PHASE_SEPS [PHASES] = '{
      8'd44, 8'h3B, csvfs_pkg::QUOTE_BYTE, csvfs_pkg::CR_BYTE, csvfs_pkg::LF_BYTE,
      csvfs_pkg::NUL_BYTE, 8'hFF, 8'h09, 8'h00
   };

   localparam csvfs_pkg::rsp_type NO_RESULT  = '0;
   localparam csvfs_pkg::rsp_type FIELD_END  = '{kind: csvfs_pkg::KIND_FIELDEND,
                                               content_byte: 8'h00, record_end: 1'b0};
   localparam csvfs_pkg::rsp_type RECORD_END = '{kind: csvfs_pkg::KIND_FIELDEND,
                                               content_byte: 8'h00, record_end: 1'b1};

   // one row of the directed script
   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_EOT,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type       op;
      logic [7:0]         value;   // text byte, or separator for a csr row
      logic               typed;   // items below are given, not predicted
      logic [1:0]         count;
      csvfs_pkg::rsp_type first;
      csvfs_pkg::rsp_type second;
   } script_row_type;

   localparam int SCRIPT_ROWS = 35;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // reset separator ','
      '{ROW_BYTE, csvfs_pkg::CR_BYTE,    1'b1, 2'd0, NO_RESULT, NO_RESULT},  // blank cr
      '{ROW_BYTE, csvfs_pkg::LF_BYTE,    1'b1, 2'd0, NO_RESULT, NO_RESULT},  // blank lf
      '{ROW_BYTE, 8'hFF, 1'b1, 2'd1, '{csvfs_pkg::KIND_CONTENT, 8'hFF, 1'b0}, NO_RESULT},
      '{ROW_BYTE, 8'h2C,                 1'b1, 2'd1, FIELD_END, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b1, 2'd0, NO_RESULT, NO_RESULT},  // opens quote
      '{ROW_BYTE, 8'h2C,                 1'b0, 2'd0, NO_RESULT, NO_RESULT},  // literal sep
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},  // doubled
      '{ROW_BYTE, csvfs_pkg::LF_BYTE,    1'b0, 2'd0, NO_RESULT, NO_RESULT},  // literal lf
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},  // closing
      '{ROW_BYTE, 8'h41, 1'b1, 2'd2, RECORD_END, '{csvfs_pkg::KIND_CONTENT, 8'h41, 1'b0}},
      '{ROW_BYTE, csvfs_pkg::CR_BYTE,    1'b1, 2'd1, RECORD_END, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::LF_BYTE,    1'b1, 2'd0, NO_RESULT, NO_RESULT},  // lf of crlf
      '{ROW_BYTE, 8'h2C,                 1'b1, 2'd1, FIELD_END, NO_RESULT},
      '{ROW_EOT,  8'hA5,                 1'b1, 2'd1, RECORD_END, NO_RESULT}, // trailing
      '{ROW_EOT,  8'h00,                 1'b1, 2'd0, NO_RESULT, NO_RESULT},  // eot, idle
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::NUL_BYTE,   1'b1, 2'd1, RECORD_END, NO_RESULT}, // nul in quote
      // separator equal to the quote
      '{ROW_CSR,  csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::LF_BYTE,    1'b1, 2'd1, RECORD_END, NO_RESULT},
      '{ROW_BYTE, 8'h62,                 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::QUOTE_BYTE, 1'b1, 2'd1, FIELD_END, NO_RESULT},  // splits
      '{ROW_BYTE, csvfs_pkg::CR_BYTE,    1'b1, 2'd1, RECORD_END, NO_RESULT},
      // separator equal to cr
      '{ROW_CSR,  csvfs_pkg::CR_BYTE,    1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::CR_BYTE,    1'b1, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, 8'h63,                 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::CR_BYTE,    1'b1, 2'd1, FIELD_END, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::LF_BYTE,    1'b1, 2'd1, RECORD_END, NO_RESULT},
      // separator zero, then the top extreme
      '{ROW_CSR,  csvfs_pkg::NUL_BYTE,   1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, 8'h64,                 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, csvfs_pkg::NUL_BYTE,   1'b1, 2'd1, RECORD_END, NO_RESULT},
      '{ROW_CSR,  8'hFF,                 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{ROW_BYTE, 8'hFF,                 1'b1, 2'd1, FIELD_END, NO_RESULT}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   csvfs_pkg::req_type req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   csvfs_pkg::rsp_type rsp_payload;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_data;

   // shadow of the splitter: separator register and parse mode
   logic [7:0]          sep_now;
   csvfs_pkg::mode_type mode_now;

   // field items still owed by the block, oldest first
   csvfs_pkg::rsp_type pending_fields [$];

   int  mismatches;
   int  items_sent;
   int  fields_seen;
   int  records_seen;
   int  backpressure_cycles;
   int  sep_writes;
   int  idle_cycles;
   bit  sender_idles;
   bit  receiver_idles;
   bit  hold_go;

   csv_field_splitter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic csvfs_pkg::rsp_type content_of(input logic [7:0] b);
      csvfs_pkg::rsp_type r;
      r.kind         = csvfs_pkg::KIND_CONTENT;
      r.content_byte = b;
      r.record_end   = 1'b0;
      return r;
   endfunction

   // field items caused by one text byte; advances the shadow parse mode
   function automatic int split_byte(input csvfs_pkg::req_type item,
                                     output csvfs_pkg::rsp_type first,
                                     output csvfs_pkg::rsp_type second);
      logic [7:0] b;
      logic       eol;
      int         n;
      b      = item.text_byte;
      eol    = (b == csvfs_pkg::CR_BYTE) || (b == csvfs_pkg::LF_BYTE);
      n      = 0;
      first  = NO_RESULT;
      second = NO_RESULT;
      // end of text closes whatever record is open
      if (item.end_of_text || b == csvfs_pkg::NUL_BYTE) begin
         if (mode_now != csvfs_pkg::MODE_LINE_START) begin
            first = RECORD_END;
            n     = 1;
         end
         mode_now = csvfs_pkg::MODE_LINE_START;
         return n;
      end
      case (mode_now)
         csvfs_pkg::MODE_LINE_START, csvfs_pkg::MODE_FIELD_START: begin
            if (mode_now == csvfs_pkg::MODE_LINE_START && eol) begin
               // blank line, nothing to emit
            end else if (b == csvfs_pkg::QUOTE_BYTE) begin
               mode_now = csvfs_pkg::MODE_QUOTED;
            end else if (b == sep_now) begin
               first    = FIELD_END;
               n        = 1;
               mode_now = csvfs_pkg::MODE_FIELD_START;
            end else if (eol) begin
               first    = RECORD_END;
               n        = 1;
               mode_now = csvfs_pkg::MODE_LINE_START;
            end else begin
               first    = content_of(b);
               n        = 1;
               mode_now = csvfs_pkg::MODE_UNQUOTED;
            end
         end
         csvfs_pkg::MODE_UNQUOTED: begin
            if (b == sep_now) begin
               first    = FIELD_END;
               n        = 1;
               mode_now = csvfs_pkg::MODE_FIELD_START;
            end else if (eol) begin
               first    = RECORD_END;
               n        = 1;
               mode_now = csvfs_pkg::MODE_LINE_START;
            end else begin
               first = content_of(b);
               n     = 1;
            end
         end
         csvfs_pkg::MODE_QUOTED: begin
            if (b == csvfs_pkg::QUOTE_BYTE) begin
               mode_now = csvfs_pkg::MODE_AFTER_QUOTE;
            end else begin
               first = content_of(b);
               n     = 1;
            end
         end
         default: begin
            // just past a quote inside a quoted field
            if (b == csvfs_pkg::QUOTE_BYTE) begin
               first    = content_of(csvfs_pkg::QUOTE_BYTE);
               n        = 1;
               mode_now = csvfs_pkg::MODE_QUOTED;
            end else if (b == sep_now) begin
               first    = FIELD_END;
               n        = 1;
               mode_now = csvfs_pkg::MODE_FIELD_START;
            end else if (eol) begin
               first    = RECORD_END;
               n        = 1;
               mode_now = csvfs_pkg::MODE_LINE_START;
            end else begin
               // stray byte: record ends, the byte opens a new record
               first    = RECORD_END;
               second   = content_of(b);
               n        = 2;
               mode_now = csvfs_pkg::MODE_UNQUOTED;
            end
         end
      endcase
      return n;
   endfunction

   // offer one text item, wait for the handshake, record what it owes
   // entered and left at a falling edge
   task automatic offer_byte(input logic [7:0] b, input logic eot, input logic typed,
                             input logic [1:0] count, input csvfs_pkg::rsp_type first,
                             input csvfs_pkg::rsp_type second);
      csvfs_pkg::req_type item;
      csvfs_pkg::rsp_type r0;
      csvfs_pkg::rsp_type r1;
      int                 n;
      item.text_byte   = b;
      item.end_of_text = eot;
      while (sender_idles && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      n = split_byte(item, r0, r1);
      if (typed) begin
         n  = count;
         r0 = first;
         r1 = second;
      end
      if (n > 0) pending_fields.push_back(r0);
      if (n > 1) pending_fields.push_back(r1);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] b);
      offer_byte(b, 1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT);
   endtask

   // stop offering, wait for every owed item, then let in-flight bytes settle
   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_separator(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sep_now = value;
      sep_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // unquoted content: anything that is not a control byte of the format
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == csvfs_pkg::QUOTE_BYTE || b == csvfs_pkg::CR_BYTE
             || b == csvfs_pkg::LF_BYTE || b == sep_now);
      return b;
   endfunction

   // one record with random fields and line ending, at times with a stray byte
   task automatic emit_record();
      int  fields;
      int  len;
      byte unsigned b;
      fields = $urandom_range(1, 4);
      if ($urandom_range(9) == 0)
         send_text($urandom_range(1) ? csvfs_pkg::CR_BYTE : csvfs_pkg::LF_BYTE);
      for (int f = 0; f < fields; f++) begin
         if (f > 0) send_text(sep_now);
         len = $urandom_range(0, 5);
         if ($urandom_range(99) < 40) begin
            send_text(csvfs_pkg::QUOTE_BYTE);
            repeat (len) begin
               if ($urandom_range(99) < 15) begin
                  send_text(csvfs_pkg::QUOTE_BYTE);
                  send_text(csvfs_pkg::QUOTE_BYTE);
               end else begin
                  do b = 8'($urandom_range(1, 255)); while (b == csvfs_pkg::QUOTE_BYTE);
                  send_text(b);
               end
            end
            send_text(csvfs_pkg::QUOTE_BYTE);
            // now and then a stray byte after the closing quote
            if ($urandom_range(9) == 0) send_text(plain_byte());
         end else begin
            repeat (len) send_text(plain_byte());
         end
      end
      case ($urandom_range(9))
         0, 1, 2: send_text(csvfs_pkg::CR_BYTE);
         3, 4, 5: send_text(csvfs_pkg::LF_BYTE);
         6, 7, 8: begin
            send_text(csvfs_pkg::CR_BYTE);
            send_text(csvfs_pkg::LF_BYTE);
         end
         default: offer_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 2'd0,
                             NO_RESULT, NO_RESULT);
      endcase
   endtask

   // short burst of raw bytes, biased toward the control bytes
   task automatic emit_noise();
      int         count;
      logic [7:0] b;
      count = $urandom_range(1, 6);
      repeat (count) begin
         case ($urandom_range(7))
            0:       b = csvfs_pkg::QUOTE_BYTE;
            1:       b = csvfs_pkg::CR_BYTE;
            2:       b = csvfs_pkg::LF_BYTE;
            3:       b = sep_now;
            default: b = 8'($urandom_range(0, 255));
         endcase
         offer_byte(b, ($urandom_range(11) == 0), 1'b0, 2'd0, NO_RESULT, NO_RESULT);
      end
   endtask

   // receiver: random stall, or a long hold-off when asked for
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(99) < 26);
         end
      end
   end

   // output side: every accepted item against the oldest owed one
   always @(posedge clock) begin : result_check
      csvfs_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         fields_seen++;
         if (rsp_payload.kind == csvfs_pkg::KIND_FIELDEND && rsp_payload.record_end)
            records_seen++;
         if (pending_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("item %0d not expected: kind %0b byte %02h record_end %0b",
                        fields_seen, rsp_payload.kind, rsp_payload.content_byte,
                        rsp_payload.record_end);
         end else begin
            want = pending_fields.pop_front();
            if (rsp_payload.kind !== want.kind
                || rsp_payload.content_byte !== want.content_byte
                || rsp_payload.record_end !== want.record_end) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("item %0d: expected kind %0b byte %02h record_end %0b, %s %0b %02h %0b",
                           fields_seen, want.kind, want.content_byte, want.record_end,
                           "got", rsp_payload.kind, rsp_payload.content_byte,
                           rsp_payload.record_end);
            end
         end
      end
      if (!reset && req_valid && req_stall) backpressure_cycles++;
   end

   // watchdog: too long without any handshake means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d items owed",
                     idle_cycles, pending_fields.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase_end;
      bit paused;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      sep_now        = csvfs_pkg::SEP_RESET;
      mode_now       = csvfs_pkg::MODE_LINE_START;
      mismatches     = 0;
      items_sent     = 0;
      fields_seen    = 0;
      records_seen   = 0;
      backpressure_cycles = 0;
      sep_writes     = 0;
      idle_cycles    = 0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_go        = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed script, starting from the reset separator
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         case (SCRIPT[i].op)
            ROW_CSR: begin
               wait_drained(SETTLE);
               write_separator(SCRIPT[i].value);
            end
            ROW_EOT: offer_byte(SCRIPT[i].value, 1'b1, SCRIPT[i].typed, SCRIPT[i].count,
                                SCRIPT[i].first, SCRIPT[i].second);
            default: offer_byte(SCRIPT[i].value, 1'b0, SCRIPT[i].typed, SCRIPT[i].count,
                                SCRIPT[i].first, SCRIPT[i].second);
         endcase
      end

      // random phases, one separator each
      for (int p = 0; p < PHASES; p++) begin
         wait_drained(SETTLE);
         write_separator((p == PHASES - 1) ? 8'($urandom_range(0, 255)) : PHASE_SEPS[p]);
         // phase 1: long receiver hold-off while bytes keep coming
         // phase 3: no idling on either side
         sender_idles   = (p != 1) && (p != 3);
         receiver_idles = (p != 3);
         if (p == 1) hold_go = 1'b1;
         phase_end = items_sent + PHASE_ITEMS;
         paused    = 1'b0;
         while (items_sent < phase_end) begin
            // phase 4: sender pauses midway until the output has caught up
            if (p == 4 && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
               wait_drained(0);
               paused = 1'b1;
            end
            if ($urandom_range(99) < 85) emit_record();
            else emit_noise();
         end
      end

      sender_idles = 1'b1;
      wait_drained(SETTLE);

      $display("covered %0d text bytes over %0d separator settings, %0d field items checked",
               items_sent, sep_writes + 1, fields_seen);
      $display("%0d records closed, input held back for %0d cycles, %0d mismatches",
               records_seen, backpressure_cycles, mismatches);
      if (mismatches == 0 && pending_fields.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/csvfs_pkg.sv
rtl/csvfs_front.sv
rtl/csvfs_queue.sv
rtl/csvfs_back.sv
rtl/csv_field_splitter.sv
sim/tb_csv_field_splitter.sv
